>>> design/htu_pkg.sv
// Shared types, constants and codes for the hybrid timebase unit.
`default_nettype none

package htu_pkg;

   // Operation codes carried in the request
   typedef enum logic [1:0] {
      OP_SLOW_EXT = 2'd0,
      OP_FAST_EXT = 2'd1,
      OP_HYBRID   = 2'd2,
      OP_SLOW_US  = 2'd3
   } op_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_HYBRID_SCALE_SHIFT   = 2'd0,
      CSR_FAST_TO_HYBRID_SHIFT = 2'd1,
      CSR_NEAR_EDGE_LIMIT      = 2'd2,
      CSR_UNUSED               = 2'd3
   } csr_index_type;

   localparam int SLOW_W     = 16;
   localparam int FAST_W     = 32;
   localparam int SHIFT_W    = 4;
   localparam int LIMIT_W    = 16;
   localparam int CSR_DATA_W = 16;

   localparam int REQ_BITS   = 2 + 2 * SLOW_W + 3 * FAST_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = 64;

   // Slow ticks (32768 Hz) times 15625 over 512 gives microseconds
   localparam int          MUL_CONST_W   = 14;
   localparam int          PROD_W        = FAST_W + MUL_CONST_W;
   localparam logic [MUL_CONST_W-1:0] SCALE_MUL = 14'd15625;
   localparam logic [SHIFT_W-1:0]     US_SHIFT  = 4'd9;

   // Reset values of the configuration registers
   localparam logic [SHIFT_W-1:0] SCALE_SHIFT_RESET = 4'd5;
   localparam logic [SHIFT_W-1:0] F2H_SHIFT_RESET   = 4'd0;
   localparam logic [LIMIT_W-1:0] EDGE_LIMIT_RESET  = 16'd502;

   // Request payload, last member in the lowest bits
   typedef struct packed {
      logic [FAST_W-1:0] slow_span;
      logic [FAST_W-1:0] fast_stamp;
      logic [FAST_W-1:0] fast_count;
      logic [SLOW_W-1:0] slow_recount;
      logic [SLOW_W-1:0] slow_count;
      op_type            opcode;
   } req_item_type;

   // Work handed from the extension stage to the scaling stage
   typedef struct packed {
      op_type                opcode;
      logic [RSP_DATA_W-1:0] pass_value;
      logic [FAST_W-1:0]     mul_operand;
      logic [SHIFT_W-1:0]    scale_shift;
      logic [FAST_W-1:0]     adjust;
      logic                  adjust_neg;
   } stage_type;

endpackage

`default_nettype wire

>>> design/htu_extend.sv
// Wrap extension of the slow and fast counters and edge delta preparation.
`default_nettype none

module htu_extend (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire logic                    in_valid,
   input  wire htu_pkg::req_item_type   in_item,
   input  wire logic [3:0]              f2h_shift,
   input  wire logic [15:0]             edge_limit,
   output      logic                    stage_valid_ff,
   output      htu_pkg::stage_type      stage_ff
);
   import htu_pkg::*;

   logic [SLOW_W-1:0] slow_high_ff, slow_high_in;
   logic [SLOW_W-1:0] slow_last_ff, slow_last_in;
   logic [FAST_W-1:0] fast_high_ff, fast_high_in;
   logic [FAST_W-1:0] fast_last_ff, fast_last_in;
   stage_type         stage_in;

   logic              take;
   logic [SLOW_W-1:0] slow_low;
   logic [SLOW_W-1:0] slow_high_new;
   logic [SLOW_W-1:0] edge_high;
   logic [FAST_W-1:0] fast_high_new;
   logic [FAST_W-1:0] delta;
   logic [FAST_W-1:0] neg_delta;

   assign take = load && in_valid;

   // Extension of the sampled counters
   always_comb begin
      slow_low      = (in_item.opcode == OP_SLOW_EXT) ? in_item.slow_count
                                                      : in_item.slow_recount;
      slow_high_new = (slow_low < slow_last_ff) ? slow_high_ff + 16'd1 : slow_high_ff;
      fast_high_new = (in_item.fast_count < fast_last_ff) ? fast_high_ff + 32'd1
                                                          : fast_high_ff;
      // second read below the edge read: undo the wrap between them
      edge_high     = (slow_low < in_item.slow_count) ? slow_high_new - 16'd1
                                                      : slow_high_new;
      delta         = in_item.fast_count - in_item.fast_stamp;
      neg_delta     = 32'd0 - delta;
   end

   // State updates
   always_comb begin
      slow_high_in = slow_high_ff;
      slow_last_in = slow_last_ff;
      fast_high_in = fast_high_ff;
      fast_last_in = fast_last_ff;
      if (take) begin
         case (in_item.opcode)
            OP_SLOW_EXT, OP_HYBRID: begin
               slow_high_in = slow_high_new;
               slow_last_in = slow_low;
            end
            OP_FAST_EXT: begin
               fast_high_in = fast_high_new;
               fast_last_in = in_item.fast_count;
            end
            default: begin
            end
         endcase
      end
   end

   // Stage payload
   always_comb begin
      stage_in             = '0;
      stage_in.opcode      = in_item.opcode;
      case (in_item.opcode)
         OP_SLOW_EXT: begin
            stage_in.pass_value = {32'd0, slow_high_new, slow_low};
         end
         OP_FAST_EXT: begin
            stage_in.pass_value = {fast_high_new, in_item.fast_count};
         end
         OP_HYBRID: begin
            stage_in.mul_operand = {edge_high, in_item.slow_count};
            stage_in.scale_shift = 4'd0;
            if (neg_delta < {16'd0, edge_limit}) begin
               stage_in.adjust     = neg_delta >> f2h_shift;
               stage_in.adjust_neg = 1'b0;
            end else begin
               stage_in.adjust     = delta >> f2h_shift;
               stage_in.adjust_neg = 1'b1;
            end
         end
         OP_SLOW_US: begin
            stage_in.mul_operand = in_item.slow_span;
            stage_in.scale_shift = US_SHIFT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_high_ff   <= '0;
         slow_last_ff   <= '0;
         fast_high_ff   <= '0;
         fast_last_ff   <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         slow_high_ff <= slow_high_in;
         slow_last_ff <= slow_last_in;
         fast_high_ff <= fast_high_in;
         fast_last_ff <= fast_last_in;
         if (load) begin
            stage_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

endmodule

`default_nettype wire

>>> design/htu_scale.sv
// Constant multiply, scaling shift, edge adjustment and result register.
`default_nettype none

module htu_scale (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire logic                 in_valid,
   input  wire htu_pkg::stage_type   stage,
   input  wire logic [3:0]           hybrid_shift,
   output      logic                 out_valid_ff,
   output      logic [63:0]          out_value_ff
);
   import htu_pkg::*;

   logic [RSP_DATA_W-1:0] out_value_in;
   logic [PROD_W-1:0]     product;
   logic [PROD_W-1:0]     shifted;
   logic [SHIFT_W-1:0]    shamt;
   logic [FAST_W-1:0]     base;
   logic [FAST_W-1:0]     signed_adj;

   // Multiply by 15625, then shift down and adjust; extension results pass through
   always_comb begin
      product    = PROD_W'(stage.mul_operand) * PROD_W'(SCALE_MUL);
      shamt      = (stage.opcode == OP_HYBRID) ? hybrid_shift : stage.scale_shift;
      shifted    = product >> shamt;
      base       = shifted[FAST_W-1:0];
      signed_adj = stage.adjust_neg ? (32'd0 - stage.adjust) : stage.adjust;
      case (stage.opcode)
         OP_SLOW_EXT, OP_FAST_EXT: out_value_in = stage.pass_value;
         OP_HYBRID:                out_value_in = {32'd0, base + signed_adj};
         OP_SLOW_US:               out_value_in = {32'd0, base};
         default:                  out_value_in = stage.pass_value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_value_ff <= out_value_in;
      end
   end

endmodule

`default_nettype wire

>>> design/hybrid_timebase_unit.sv
// Top level of the hybrid timebase unit: request register, pipeline, registers.
//
//   channel  | direction | handshake             | payload
//   req      | in        | req_tvalid/req_tready | req_tdata: opcode, counter samples
//   rsp      | out       | rsp_tvalid/rsp_tready | rsp_tdata: 64-bit value
//   csr      | in        | csr_we                | csr_index, csr_wdata
//
// One request per clock while no stage is stalled; a result passes the request
// register, then the extension stage, then the result register.
// Each stage holds its item while the one after it is full and stalled.
// Synchronous reset clears the wrap state, the valid flags and loads the
// register reset values.
`default_nettype none

module hybrid_timebase_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   // slave side
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // opcode[1:0], slow_count[17:2], slow_recount[33:18], fast_count[65:34],
   // fast_stamp[97:66], slow_span[129:98], zero fill above
   input  wire logic [htu_pkg::REQ_DATA_W-1:0] req_tdata,
   // master side
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // value[63:0]
   output      logic [htu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration writes
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [htu_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import htu_pkg::*;

   logic [SHIFT_W-1:0] scale_shift_ff;
   logic [SHIFT_W-1:0] f2h_shift_ff;
   logic [LIMIT_W-1:0] edge_limit_ff;

   logic               req_valid_ff;
   req_item_type       req_item_ff;
   logic               ext_valid;
   stage_type          ext_stage;
   logic               out_valid;
   logic [63:0]        out_value;

   logic               rdy_out;
   logic               rdy_ext;
   logic               rdy_req;

   // Ready chain back from the result register
   assign rdy_out    = !out_valid || rsp_tready;
   assign rdy_ext    = !ext_valid || rdy_out;
   assign rdy_req    = !req_valid_ff || rdy_ext;
   assign req_tready = rdy_req;
   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = out_value;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_shift_ff <= SCALE_SHIFT_RESET;
         f2h_shift_ff   <= F2H_SHIFT_RESET;
         edge_limit_ff  <= EDGE_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_HYBRID_SCALE_SHIFT:   scale_shift_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_FAST_TO_HYBRID_SHIFT: f2h_shift_ff   <= csr_wdata[SHIFT_W-1:0];
            CSR_NEAR_EDGE_LIMIT:      edge_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (rdy_req) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_req) begin
         req_item_ff <= req_tdata[REQ_BITS-1:0];
      end
   end

   htu_extend u_extend (
      .clock          (clock),
      .reset          (reset),
      .load           (rdy_ext),
      .in_valid       (req_valid_ff),
      .in_item        (req_item_ff),
      .f2h_shift      (f2h_shift_ff),
      .edge_limit     (edge_limit_ff),
      .stage_valid_ff (ext_valid),
      .stage_ff       (ext_stage)
   );

   htu_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .load         (rdy_out),
      .in_valid     (ext_valid),
      .stage        (ext_stage),
      .hybrid_shift (scale_shift_ff),
      .out_valid_ff (out_valid),
      .out_value_ff (out_value)
   );

endmodule

`default_nettype wire

>>> dv/hybrid_timebase_unit_checker.sv
// Result checker for the hybrid timebase unit: predicts each response and compares it.
`default_nettype none

module hybrid_timebase_unit_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [135:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [63:0]  rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata,
   output int                pending,
   output int                fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import htu_pkg::*;

   // Register copies
   logic [SHIFT_W-1:0] scale_shift;
   logic [SHIFT_W-1:0] f2h_shift;
   logic [LIMIT_W-1:0] edge_limit;

   // Wrap extension state
   logic [SLOW_W-1:0] slow_hi;
   logic [SLOW_W-1:0] slow_last;
   logic [FAST_W-1:0] fast_hi;
   logic [FAST_W-1:0] fast_last;

   logic [RSP_DATA_W-1:0] expected_values[$];
   int mismatches = 0;

   // Extend a slow sample; bumps the high half when the low half goes backward
   function automatic logic [31:0] extend_slow_sample(logic [SLOW_W-1:0] low);
      if (low < slow_last) slow_hi = slow_hi + 16'd1;
      slow_last = low;
      return {slow_hi, low};
   endfunction

   // Timebase value for one request; updates the wrap state as the unit does
   function automatic logic [63:0] predict_value(req_item_type item);
      logic [31:0] ext;
      logic [15:0] hi;
      logic [63:0] prod;
      logic [31:0] h;
      logic [31:0] d;
      logic [31:0] n;
      case (item.opcode)
         OP_SLOW_EXT: begin
            return {32'd0, extend_slow_sample(item.slow_count)};
         end
         OP_FAST_EXT: begin
            if (item.fast_count < fast_last) fast_hi = fast_hi + 32'd1;
            fast_last = item.fast_count;
            return {fast_hi, item.fast_count};
         end
         OP_HYBRID: begin
            ext = extend_slow_sample(item.slow_recount);
            hi = ext[31:16];
            // recount wrapped past the edge sample: step the high half back
            if (ext[15:0] < item.slow_count) hi = hi - 16'd1;
            prod = 64'({hi, item.slow_count}) * 64'(SCALE_MUL);
            h = 32'(prod >> scale_shift);
            d = item.fast_count - item.fast_stamp;
            n = 32'd0 - d;
            if (n < 32'(edge_limit)) h = h + (n >> f2h_shift);
            else h = h - (d >> f2h_shift);
            return {32'd0, h};
         end
         default: begin
            return {32'd0, 32'((64'(item.slow_span) * 64'(SCALE_MUL)) >> US_SHIFT)};
         end
      endcase
   endfunction

   // Track register writes, request transfers and response transfers
   always @(posedge clock) begin
      logic [63:0] want;
      if (reset) begin
         scale_shift = SCALE_SHIFT_RESET;
         f2h_shift   = F2H_SHIFT_RESET;
         edge_limit  = EDGE_LIMIT_RESET;
         slow_hi     = '0;
         slow_last   = '0;
         fast_hi     = '0;
         fast_last   = '0;
         expected_values.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_HYBRID_SCALE_SHIFT:   scale_shift = csr_wdata[SHIFT_W-1:0];
               CSR_FAST_TO_HYBRID_SHIFT: f2h_shift   = csr_wdata[SHIFT_W-1:0];
               CSR_NEAR_EDGE_LIMIT:      edge_limit  = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         // compare before queuing, so a response never matches a same-edge request
         if (rsp_tvalid && rsp_tready) begin
            if (expected_values.size() == 0) begin
               $error("value: no transfer outstanding, expected none, actual %h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_values.pop_front();
               if (rsp_tdata !== want) begin
                  $error("value: expected %h, actual %h", want, rsp_tdata);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_values.push_back(predict_value(req_item_type'(req_tdata[REQ_BITS-1:0])));
      end
      pending    <= expected_values.size();
      fail_count <= mismatches;
   end

endmodule

`default_nettype wire

>>> dv/hybrid_timebase_unit_tb.sv
// Testbench top for the hybrid timebase unit: clock, reset, stimulus and verdict.
`default_nettype none

module hybrid_timebase_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import htu_pkg::*;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         csr_we     = 1'b0;
   logic [1:0]   csr_index  = CSR_HYBRID_SCALE_SHIFT;
   logic [15:0]  csr_wdata  = '0;

   int pending;
   int fail_count;

   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int unsigned cur_limit      = EDGE_LIMIT_RESET;
   logic [15:0] slow_now       = '0;
   logic [31:0] fast_now       = '0;

   hybrid_timebase_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   hybrid_timebase_unit_checker result_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver backpressure
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   function automatic req_item_type compose_request(op_type op, logic [15:0] sc,
         logic [15:0] sr, logic [31:0] fc, logic [31:0] ft, logic [31:0] st);
      req_item_type item;
      item.opcode       = op;
      item.slow_count   = sc;
      item.slow_recount = sr;
      item.fast_count   = fc;
      item.fast_stamp   = ft;
      item.slow_span    = st;
      return item;
   endfunction

   // One request transfer, with an optional idle gap in front
   task automatic send_item(input req_item_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(136 - REQ_BITS){1'b0}}, item};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold off requests until every response is back, then idle before the next phase
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (6) @(posedge clock);
   endtask

   // Write all registers back to back; junk in the unused upper bits
   task automatic load_config(input logic [3:0] scale, input logic [3:0] f2h,
                              input logic [15:0] limit);
      csr_we    <= 1'b1;
      csr_index <= CSR_HYBRID_SCALE_SHIFT;
      csr_wdata <= {12'($urandom), scale};
      @(posedge clock);
      csr_index <= CSR_FAST_TO_HYBRID_SHIFT;
      csr_wdata <= {12'($urandom), f2h};
      @(posedge clock);
      csr_index <= CSR_NEAR_EDGE_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_limit = limit;
   endtask

   // Random traffic: mostly timer reads that advance like live counters
   task automatic run_phase(input int count, input int idle, input int stall);
      req_item_type item;
      int unsigned  k;
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      repeat (count) begin
         item.opcode       = op_type'($urandom_range(3));
         item.slow_count   = 16'($urandom);
         item.slow_recount = 16'($urandom);
         item.fast_count   = $urandom;
         item.fast_stamp   = $urandom;
         item.slow_span    = $urandom;
         if ($urandom_range(99) < 75) begin
            case ($urandom_range(3))
               0: ;
               1: begin
                  slow_now += 16'($urandom_range(1, 16));
                  fast_now += $urandom_range(1, 8000);
               end
               2: begin
                  slow_now += 16'($urandom_range(1, 4096));
                  fast_now += $urandom_range(1, 1 << 24);
               end
               default: begin
                  slow_now = 16'($urandom);
                  fast_now = $urandom;
               end
            endcase
            item.slow_count   = slow_now;
            item.slow_recount = slow_now + 16'($urandom_range(3));
            item.fast_count   = fast_now;
            // capture lands near the edge window, on either side
            k = $urandom_range(2 * cur_limit + 2);
            item.fast_stamp = $urandom_range(1) ? fast_now + k : fast_now - k;
         end
         send_item(item);
      end
   endtask

   // Main sequence
   initial begin
      req_item_type directed_items[$];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // edge undo with high half at zero wraps it
      directed_items.push_back(compose_request(OP_HYBRID, 16'hFFFF, 16'h0000, 0, 0, 0));
      directed_items.push_back(compose_request(OP_SLOW_EXT, 16'h0000, 0, 0, 0, 0));
      directed_items.push_back(compose_request(OP_SLOW_EXT, 16'hFFFF, 0, 0, 0, 0));
      directed_items.push_back(compose_request(OP_SLOW_EXT, 16'h0000, 0, 0, 0, 0));
      directed_items.push_back(compose_request(OP_FAST_EXT, 0, 0, 32'hFFFF_FFFF, 0, 0));
      directed_items.push_back(compose_request(OP_FAST_EXT, 0, 0, 32'h0000_0000, 0, 0));
      directed_items.push_back(compose_request(OP_FAST_EXT, 0, 0, 32'h0000_0000, 0, 0));
      // just inside, on and past the edge window
      directed_items.push_back(compose_request(OP_HYBRID, 100, 100, 1000, 1000 + 501, 0));
      directed_items.push_back(compose_request(OP_HYBRID, 100, 100, 1000, 1000 + 502, 0));
      directed_items.push_back(compose_request(OP_HYBRID, 100, 100, 1000, 999, 0));
      directed_items.push_back(compose_request(OP_HYBRID, 100, 100, 1000, 1000, 0));
      directed_items.push_back(compose_request(OP_HYBRID, 16'hFFFF, 16'hFFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      // recount wraps past the edge sample
      directed_items.push_back(compose_request(OP_HYBRID, 16'hFFF0, 16'h0005,
            0, 32'hFFFF_FFFF, 0));
      directed_items.push_back(compose_request(OP_HYBRID, 0, 0, 32'h8000_0000, 0, 0));
      directed_items.push_back(compose_request(OP_SLOW_US, 0, 0, 0, 0, 0));
      directed_items.push_back(compose_request(OP_SLOW_US, 16'hFFFF, 16'hFFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      directed_items.push_back(compose_request(OP_SLOW_US, 0, 0, 0, 0, 1));
      directed_items.push_back(compose_request(OP_SLOW_US, 0, 0, 0, 0, 32768));
      foreach (directed_items[i]) send_item(directed_items[i]);
      drain_results();

      load_config(4'd0, 4'd0, 16'd0);
      run_phase(230, 0, 0);
      drain_results();
      load_config(4'd15, 4'd15, 16'hFFFF);
      run_phase(230, 62, 0);
      drain_results();
      load_config(4'($urandom), 4'($urandom), 16'($urandom));
      run_phase(230, 0, 62);
      drain_results();
      load_config(4'd9, 4'd3, 16'd502);
      run_phase(230, 35, 35);
      drain_results();
      load_config(4'($urandom), 4'($urandom_range(4)), 16'($urandom_range(2000)));
      run_phase(230, 35, 35);
      drain_results();
      load_config(4'($urandom), 4'($urandom), 16'($urandom));
      run_phase(230, 0, 0);
      drain_results();

      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
